// File: hdl/swu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swu_pkg
// Shared types, register indexes and decay factors of the STDP weight update.
// ----------------------------------------------------------------------------
package swu_pkg;

	localparam int W_ID    = 32;
	localparam int W_WT    = 17;
	localparam int W_DT    = 16;
	localparam int W_DW    = 18;
	localparam int W_TAU   = 16;
	localparam int W_CFG   = 17;
	localparam int W_IDX   = 2;
	localparam int X_BITS  = 20;
	localparam int R_BITS  = 31;
	localparam int C_BITS  = 30;
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 88;

	localparam logic [W_IDX-1:0] REG_GAIN_POT = 2'd0;
	localparam logic [W_IDX-1:0] REG_GAIN_DEP = 2'd1;
	localparam logic [W_IDX-1:0] REG_TAU      = 2'd2;

	localparam logic [W_CFG-1:0] RST_GAIN_POT = 17'd3277;
	localparam logic [W_CFG-1:0] RST_GAIN_DEP = 17'd2621;
	localparam logic [W_TAU-1:0] RST_TAU      = 16'd1280;

	localparam logic [W_WT-1:0] WT_ONE = 17'd65536;

	// round(exp(-2^(k-16)) * 2^30) for bit k of the Q4.16 exponent argument
	localparam logic [C_BITS-1:0] EXP_C [X_BITS] = '{
		30'd1073725440, 30'd1073709056, 30'd1073676290, 30'd1073610760,
		30'd1073479712, 30'd1073217664, 30'd1072693760, 30'd1071646719,
		30'd1069555701, 30'd1065385899, 30'd1057095000, 30'd1040706261,
		30'd1008687096, 30'd947573834,  30'd836230973,  30'd651257337,
		30'd395007542,  30'd145315154,  30'd19666268,   30'd360200
	};

	typedef struct packed {
		logic [W_ID-1:0]  id;
		logic [W_WT-1:0]  weight;
		logic [W_DT-1:0]  mag;
		logic             ltp;
		logic [W_CFG-1:0] gain;
	} swu_item_t;

	typedef struct packed {
		swu_item_t item;
		logic      ovf;
	} swu_ctx_t;

endpackage

// File: hdl/swu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swu_front
// Input side: splits the time difference into magnitude and sign, picks the gain.
// ----------------------------------------------------------------------------
module swu_front (
	input  logic [swu_pkg::W_ID-1:0]  syn_id,
	input  logic [swu_pkg::W_WT-1:0]  weight_in,
	input  logic [swu_pkg::W_DT-1:0]  time_difference,
	input  logic [swu_pkg::W_CFG-1:0] gain_potentiation,
	input  logic [swu_pkg::W_CFG-1:0] gain_depression,
	output swu_pkg::swu_item_t        item
);
	import swu_pkg::*;

	logic ltp;

	always_comb begin
		// Positive difference means post fired after pre: potentiation.
		ltp = !time_difference[W_DT-1] && (time_difference != '0);
		item.id     = syn_id;
		item.weight = weight_in;
		item.mag    = time_difference[W_DT-1] ? (~time_difference + 16'd1) : time_difference;
		item.ltp    = ltp;
		item.gain   = ltp ? gain_potentiation : gain_depression;
	end

endmodule

// File: hdl/swu_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swu_fifo
// Four-entry queue of classified transactions between front and back.
// ----------------------------------------------------------------------------
module swu_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  swu_pkg::swu_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               valid,
	output swu_pkg::swu_item_t head
);
	import swu_pkg::*;

	swu_item_t  mem_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full    = count_q[2];
	assign valid   = count_q != 3'd0;
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 2'd1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 2'd1;
			if (do_push && !do_pop)      count_q <= count_q + 3'd1;
			else if (do_pop && !do_push) count_q <= count_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_item;
	end

endmodule

// File: hdl/swu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swu_back
// Execution pipeline: divide by tau, exponential decay, gain scaling, clamp.
// ----------------------------------------------------------------------------
module swu_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [swu_pkg::W_TAU-1:0] tau,
	input  logic                      in_valid,
	input  swu_pkg::swu_item_t        in_item,
	output logic                      in_pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [swu_pkg::W_ID-1:0]  out_id,
	output logic [swu_pkg::W_WT-1:0]  out_weight_before,
	output logic [swu_pkg::W_WT-1:0]  out_weight_after,
	output logic [swu_pkg::W_DW-1:0]  out_weight_change,
	output logic                      out_ltp
);
	import swu_pkg::*;

	// index 0 entry, 1..20 division, 21..40 decay, 41 exp round, 42 scaling
	localparam int LAST = 42;
	localparam logic [R_BITS-1:0] R_ONE = 31'h4000_0000;

	logic                  adv;
	logic                  vld_s [LAST+1];
	swu_ctx_t              ctx_s [LAST+1];
	logic [W_TAU-1:0]      rem_s [X_BITS+1];
	logic [X_BITS-1:0]     q_s   [X_BITS+1];
	logic [R_BITS-1:0]     r_s   [1:X_BITS];
	logic [X_BITS-1:0]     x_s   [1:X_BITS];
	logic [W_WT-1:0]       e_s;
	logic [W_WT-1:0]       dmag_s;
	logic                  out_valid_q;
	logic [W_ID-1:0]       id_q;
	logic [W_WT-1:0]       wb_q;
	logic [W_WT-1:0]       wa_q;
	logic [W_DW-1:0]       dw_q;
	logic                  ltp_q;
	logic [33:0]           scale_prod;
	logic [W_DW-1:0]       dw_next;
	logic signed [19:0]    nw_next;
	logic [W_WT-1:0]       wa_next;

	assign adv    = !out_valid_q || out_ready;
	assign in_pop = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= LAST; i++) vld_s[i] <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_valid;
			for (int i = 1; i <= LAST; i++) vld_s[i] <= vld_s[i-1];
			out_valid_q <= vld_s[LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s[0].item <= in_item;
			// Quotient of 2^20 or more saturates the decay to zero.
			ctx_s[0].ovf  <= {4'b0, in_item.mag} >= {tau, 4'b0};
			rem_s[0]      <= {4'b0, in_item.mag[W_DT-1:4]};
			q_s[0]        <= '0;
			for (int i = 1; i <= LAST; i++) ctx_s[i] <= ctx_s[i-1];
		end
	end

	// Restoring division, one quotient bit per stage, most significant first.
	for (genvar i = 1; i <= X_BITS; i++) begin : g_div
		localparam int K = X_BITS - i;
		logic            nb;
		logic [16:0]     shifted;
		logic [17:0]     trial;
		logic [X_BITS-1:0] q_next;
		if (K >= 16) begin : g_num
			assign nb = ctx_s[i-1].item.mag[K-16];
		end else begin : g_zero
			assign nb = 1'b0;
		end
		always_comb begin
			shifted = {rem_s[i-1], nb};
			trial   = {1'b0, shifted} - {2'b0, tau};
			q_next  = q_s[i-1];
			q_next[K] = !trial[17];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[i] <= trial[17] ? shifted[W_TAU-1:0] : trial[W_TAU-1:0];
				q_s[i]   <= q_next;
			end
		end
	end

	// exp(-x) as a product of per-bit factors, one multiplication per stage.
	for (genvar j = 1; j <= X_BITS; j++) begin : g_exp
		logic [R_BITS-1:0] r_prev;
		logic [X_BITS-1:0] x_prev;
		logic [60:0]       prod;
		if (j == 1) begin : g_first
			assign r_prev = R_ONE;
			assign x_prev = q_s[X_BITS];
		end else begin : g_next
			assign r_prev = r_s[j-1];
			assign x_prev = x_s[j-1];
		end
		assign prod = 61'(r_prev) * 61'(EXP_C[j-1]) + 61'h2000_0000;
		always_ff @(posedge clk) begin
			if (adv) begin
				r_s[j] <= x_prev[j-1] ? prod[60:30] : r_prev;
				x_s[j] <= x_prev;
			end
		end
	end

	logic [R_BITS-1:0] r_rnd;
	assign r_rnd = r_s[X_BITS] + 31'h2000;

	assign scale_prod = 34'(ctx_s[LAST-1].item.gain) * 34'(e_s) + 34'h8000;

	always_ff @(posedge clk) begin
		if (adv) begin
			e_s    <= ctx_s[LAST-2].ovf ? '0 : r_rnd[30:14];
			dmag_s <= scale_prod[32:16];
		end
	end

	always_comb begin
		dw_next = ctx_s[LAST].item.ltp ? {1'b0, dmag_s} : (~{1'b0, dmag_s} + 18'd1);
		nw_next = $signed({3'b0, ctx_s[LAST].item.weight}) + $signed({{2{dw_next[17]}}, dw_next});
		if (nw_next < 0)                              wa_next = '0;
		else if (nw_next > $signed({3'b0, WT_ONE}))   wa_next = WT_ONE;
		else                                          wa_next = nw_next[W_WT-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			id_q  <= ctx_s[LAST].item.id;
			wb_q  <= ctx_s[LAST].item.weight;
			wa_q  <= wa_next;
			dw_q  <= dw_next;
			ltp_q <= ctx_s[LAST].item.ltp;
		end
	end

	assign out_valid         = out_valid_q;
	assign out_id            = id_q;
	assign out_weight_before = wb_q;
	assign out_weight_after  = wa_q;
	assign out_weight_change = dw_q;
	assign out_ltp           = ltp_q;

endmodule

// File: hdl/stdp_weight_update_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stdp_weight_update_unit
// Pair-based STDP weight update with an exponential timing window.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Carries
//   s_axis    in         synapse id, weight, signed spike time difference
//   m_axis    out        id, old weight, new weight, signed change; LTP flag
//   cfg       in         gain_potentiation, gain_depression, time_constant
//
// One transaction is accepted per cycle and one result leaves per cycle when
// the output side keeps up. The pipeline is built around the 20-stage restoring
// divider and the 20-stage chain of decay multipliers. Reset clears the queue
// and the pipeline valid bits and sets the configuration registers to their
// defaults. A stall on m_axis freezes the whole back pipeline; the four-entry
// queue keeps s_axis flowing until it fills.
//
module stdp_weight_update_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// [31:0] syn_id, [48:32] weight_in, [64:49] time_difference, zero pad
	input  logic [swu_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// [31:0] syn_id_out, [48:32] weight_before, [65:49] weight_after,
	// [83:66] weight_change, zero pad
	output logic [swu_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// [0] is_potentiation
	output logic                          m_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	input  logic                          cfg_we,
	input  logic [swu_pkg::W_IDX-1:0]     cfg_index,
	input  logic [swu_pkg::W_CFG-1:0]     cfg_data
);
	import swu_pkg::*;

	logic [W_CFG-1:0] gain_pot_q;
	logic [W_CFG-1:0] gain_dep_q;
	logic [W_TAU-1:0] tau_q;
	logic [W_TAU-1:0] tau_eff;
	swu_item_t        front_item;
	swu_item_t        queue_head;
	logic             queue_full;
	logic             queue_valid;
	logic             back_pop;
	logic [W_ID-1:0]  res_id;
	logic [W_WT-1:0]  res_wb;
	logic [W_WT-1:0]  res_wa;
	logic [W_DW-1:0]  res_dw;

	// Configuration registers; the user must write these only while the block is idle, which the block does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_pot_q <= RST_GAIN_POT;
			gain_dep_q <= RST_GAIN_DEP;
			tau_q      <= RST_TAU;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAIN_POT: gain_pot_q <= cfg_data;
				REG_GAIN_DEP: gain_dep_q <= cfg_data;
				REG_TAU:      tau_q      <= cfg_data[W_TAU-1:0];
				default:      ;
			endcase
		end
	end

	// A zero time constant behaves as one.
	assign tau_eff = (tau_q == '0) ? 16'd1 : tau_q;

	swu_front u_front (
		.syn_id            (s_axis_tdata[31:0]),
		.weight_in         (s_axis_tdata[48:32]),
		.time_difference   (s_axis_tdata[64:49]),
		.gain_potentiation (gain_pot_q),
		.gain_depression   (gain_dep_q),
		.item              (front_item)
	);

	assign s_axis_tready = !queue_full;

	swu_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_axis_tvalid),
		.push_item (front_item),
		.full      (queue_full),
		.pop       (back_pop),
		.valid     (queue_valid),
		.head      (queue_head)
	);

	swu_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.tau               (tau_eff),
		.in_valid          (queue_valid),
		.in_item           (queue_head),
		.in_pop            (back_pop),
		.out_valid         (m_axis_tvalid),
		.out_ready         (m_axis_tready),
		.out_id            (res_id),
		.out_weight_before (res_wb),
		.out_weight_after  (res_wa),
		.out_weight_change (res_dw),
		.out_ltp           (m_axis_tuser)
	);

	assign m_axis_tdata = {4'b0, res_dw, res_wa, res_wb, res_id};

endmodule

// File: bench/stdp_weight_update_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stdp_weight_update_unit_test
// Streams spike pairs through the STDP weight update unit under several gain
// and time constant settings and checks every result against a local model.
// ----------------------------------------------------------------------------
module stdp_weight_update_unit_test;
	import swu_pkg::*;

	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 60;

	// One expected weight update, as the unit should report it.
	typedef struct {
		logic [W_ID-1:0] id;
		logic [W_WT-1:0] w_old;
		logic [W_WT-1:0] w_new;
		logic [W_DW-1:0] dw;
		logic            ltp;
	} update_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic m_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic cfg_we = 1'b0;
	logic [W_IDX-1:0] cfg_index = '0;
	logic [W_CFG-1:0] cfg_data = '0;

	// Local copy of the three configuration registers.
	logic [W_CFG-1:0] gain_ltp;
	logic [W_CFG-1:0] gain_ltd;
	logic [W_TAU-1:0] tau;

	update_t pending_updates[$];
	int mismatches = 0;
	int updates_checked = 0;
	int idle_cycles = 0;
	bit sink_stalls = 1'b1;

	stdp_weight_update_unit DUT (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Decay factor exp(-x) in Q1.16, built from the per-bit factors.
	function automatic logic [16:0] decay(input logic [31:0] x);
		logic [63:0] r;
		r = 64'd1 << 30;
		if (x >= (32'd16 << 16))
			return '0;
		for (int k = 0; k < X_BITS; k++) begin
			if (x[k])
				r = (r * EXP_C[k] + (64'd1 << 29)) >> 30;
		end
		return 17'((r + (64'd1 << 13)) >> 14);
	endfunction

	function automatic update_t predict_update(input logic [W_ID-1:0] id,
			input logic [W_WT-1:0] w, input logic signed [W_DT-1:0] dt);
		update_t u;
		logic [16:0] mag;
		logic [31:0] divisor, x;
		logic [63:0] e, g, dmag;
		longint nw;
		mag = (dt < 0) ? 17'(-int'(dt)) : 17'(int'(dt));
		divisor = (tau == 0) ? 32'd1 : 32'(tau);
		x = 32'((64'(mag) << 16) / divisor);
		e = 64'(decay(x));
		u.ltp = dt > 0;
		g = u.ltp ? 64'(gain_ltp) : 64'(gain_ltd);
		dmag = (g * e + 64'd32768) >> 16;
		nw = u.ltp ? longint'(w) + longint'(dmag) : longint'(w) - longint'(dmag);
		if (nw < 0)
			nw = 0;
		if (nw > 65536)
			nw = 65536;
		u.id = id;
		u.w_old = w;
		u.w_new = W_WT'(nw);
		u.dw = u.ltp ? W_DW'(dmag) : W_DW'(-dmag);
		return u;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %0s: got %0h, expected %0h", what, got, want);
		mismatches++;
	endtask

	// Random gap: mostly zero or short, sometimes long.
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// With no gap, valid stays high so the next pair follows directly.
	task automatic send_pair(input logic [W_ID-1:0] id, input logic [W_WT-1:0] w,
			input logic signed [W_DT-1:0] dt);
		int gap;
		gap = gap_length();
		pending_updates.push_back(predict_update(id, w, dt));
		s_axis_tdata <= {7'd0, dt, w, id};
		s_axis_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Result side: random stall while sink_stalls is set, check each accepted transaction in order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_updates.size() == 0) begin
					report_mismatch("unexpected result", m_axis_tdata[63:0], 0);
				end else begin
					update_t u;
					u = pending_updates.pop_front();
					updates_checked++;
					if (m_axis_tdata[31:0] !== u.id)
						report_mismatch("syn_id_out", m_axis_tdata[31:0], u.id);
					if (m_axis_tdata[48:32] !== u.w_old)
						report_mismatch("weight_before", m_axis_tdata[48:32], u.w_old);
					if (m_axis_tdata[65:49] !== u.w_new)
						report_mismatch("weight_after", m_axis_tdata[65:49], u.w_new);
					if (m_axis_tdata[83:66] !== u.dw)
						report_mismatch("weight_change", m_axis_tdata[83:66], u.dw);
					if (m_axis_tuser !== u.ltp)
						report_mismatch("is_potentiation", m_axis_tuser, u.ltp);
				end
			end
			m_axis_tready <= sink_stalls ? ($urandom_range(0, 99) < 70) : 1'b1;
		end
	end

	// Watchdog on cycles where neither side moves a transaction.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired with %0d results outstanding",
				pending_updates.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Stop sending, wait for every outstanding result, then for the pipeline
	// to go quiet.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_updates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Leaves the write enable high; the caller drops it after the last write.
	task automatic write_reg(input logic [W_IDX-1:0] idx, input logic [W_CFG-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_GAIN_POT: gain_ltp = val;
			REG_GAIN_DEP: gain_ltd = val;
			REG_TAU: tau = W_TAU'(val);
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [W_CFG-1:0] gp, input logic [W_CFG-1:0] gd,
			input logic [W_TAU-1:0] tc);
		drain();
		write_reg(REG_GAIN_POT, gp);
		write_reg(REG_GAIN_DEP, gd);
		write_reg(REG_TAU, 17'(tc));
		cfg_we <= 1'b0;
	endtask

	// Field extremes, dt sign boundaries and saturation at both ends.
	task automatic test_directed();
		send_pair(32'h0, 17'd0, 16'sd0);
		send_pair(32'hFFFF_FFFF, 17'd65536, 16'sd0);
		send_pair(32'h1, 17'd65536, 16'sd1);
		send_pair(32'h2, 17'd0, -16'sd1);
		send_pair(32'h3, 17'd32768, 16'sd32767);
		send_pair(32'h4, 17'd32768, -16'sd32768);
		send_pair(32'h5, 17'h1FFFF, 16'sd100);
		send_pair(32'h6, 17'h1FFFF, -16'sd100);
		send_pair(32'hAAAA_5555, 17'd1000, 16'sd1280);
		send_pair(32'h5555_AAAA, 17'd65000, -16'sd1280);
		send_pair(32'h8000_0000, 17'd65535, 16'sd20480);
		send_pair(32'h7FFF_FFFF, 17'd500, -16'sd20479);
	endtask

	// Mostly physiological time differences, with the whole range now and then.
	task automatic test_random(input int count);
		logic [W_WT-1:0] w;
		logic signed [W_DT-1:0] dt;
		for (int i = 0; i < count; i++) begin
			w = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
			if ($urandom_range(0, 3) == 0)
				dt = 16'($urandom);
			else
				dt = 16'($signed($urandom_range(0, 8000)) - 4000);
			send_pair($urandom, w, dt);
		end
	endtask

	// Gain and time constant extremes, including a zero time constant.
	task automatic test_settings();
		set_config(17'd65536, 17'd65536, 16'd1);
		test_directed();
		test_random(100);
		set_config(17'h1FFFF, 17'h1FFFF, 16'd0);
		test_random(60);
		set_config(17'd0, 17'd0, 16'hFFFF);
		test_directed();
		test_random(60);
		set_config(17'($urandom), 17'($urandom), 16'($urandom));
		sink_stalls = 1'b0;
		test_random(120);
		sink_stalls = 1'b1;
		set_config(RST_GAIN_POT, RST_GAIN_DEP, RST_TAU);
		test_random(150);
	endtask

	initial begin
		gain_ltp = RST_GAIN_POT;
		gain_ltd = RST_GAIN_DEP;
		tau = RST_TAU;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(200);
		test_settings();
		drain();
		$display("Checked %0d weight updates across reset, extreme and random settings,",
			updates_checked);
		$display("covering potentiation, depression, saturation and stalls on both sides.");
		if (mismatches == 0 && pending_updates.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: files.f
hdl/swu_pkg.sv
hdl/swu_front.sv
hdl/swu_fifo.sv
hdl/swu_back.sv
hdl/stdp_weight_update_unit.sv
bench/stdp_weight_update_unit_test.sv
